// ----- rtl/qmrp_pkg.sv -----
// Shared constants for the quaternion to MRP converter.
`default_nettype none
package qmrp_pkg;
  localparam int DEFAULT_COMPONENT_WIDTH = 16;
  localparam int GUARD_BITS = 8;
endpackage
`default_nettype wire

// ----- rtl/qmrp_sqrt.sv -----
// Pipelined restoring integer square root, one result bit per stage.
`default_nettype none
module qmrp_sqrt import qmrp_pkg::*; #(
  parameter int W      = DEFAULT_COMPONENT_WIDTH,
  parameter int G      = GUARD_BITS,
  parameter int SIDE_W = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2*W:0]       in_sum,
  input  wire logic [SIDE_W-1:0]  in_side,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [W+G:0]            out_root,
  output logic [SIDE_W-1:0]       out_side
);
  localparam int NR    = W + G + 1;
  localparam int RAD_W = 2 * NR;
  localparam int REM_W = NR + 3;

  logic [RAD_W-1:0]  rad_r  [0:NR-1];
  logic [NR-1:0]     root_r [0:NR-1];
  logic [REM_W-1:0]  rem_r  [0:NR-1];
  logic [SIDE_W-1:0] side_r [0:NR-1];
  logic [NR-1:0]     vld_r;
  logic [NR-1:0]     rdy;

  logic [RAD_W-1:0] rad_in;
  assign rad_in = {1'b0, in_sum, {(2*G){1'b0}}};

  genvar k;
  generate
    for (k = 0; k < NR; k++) begin : g_stage
      localparam int PI = NR - 1 - k;
      logic [RAD_W-1:0]  rad_i;
      logic [NR-1:0]     root_i;
      logic [REM_W-1:0]  rem_i;
      logic [SIDE_W-1:0] side_i;
      logic              vld_i;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              ge;

      if (k == 0) begin : g_first
        assign rad_i  = rad_in;
        assign root_i = '0;
        assign rem_i  = '0;
        assign side_i = in_side;
        assign vld_i  = in_valid;
      end else begin : g_next
        assign rad_i  = rad_r[k-1];
        assign root_i = root_r[k-1];
        assign rem_i  = rem_r[k-1];
        assign side_i = side_r[k-1];
        assign vld_i  = vld_r[k-1];
      end

      if (k == NR - 1) begin : g_last_rdy
        assign rdy[k] = ~vld_r[k] | out_ready;
      end else begin : g_mid_rdy
        assign rdy[k] = ~vld_r[k] | rdy[k+1];
      end

      // bring down the next radicand bit pair and try the new root bit
      assign rem_sh = {rem_i[REM_W-3:0], rad_i[2*PI+1 -: 2]};
      assign trial  = {1'b0, root_i, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld_r[k] <= vld_i;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && vld_i) begin
          rad_r[k]  <= rad_i;
          side_r[k] <= side_i;
          root_r[k] <= {root_i[NR-2:0], ge};
          rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NR-1];
  assign out_root  = root_r[NR-1];
  assign out_side  = side_r[NR-1];
endmodule
`default_nettype wire

// ----- rtl/qmrp_div.sv -----
// Three-lane pipelined restoring divider sharing one divisor, one bit per stage.
`default_nettype none
module qmrp_div import qmrp_pkg::*; #(
  parameter int W      = DEFAULT_COMPONENT_WIDTH,
  parameter int G      = GUARD_BITS,
  parameter int SIDE_W = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [W+G:0]             in_d,
  input  wire logic [2:0][W-1:0]        in_m,
  input  wire logic [SIDE_W-1:0]        in_side,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [W+G:0]                  out_d,
  output logic [2:0][W-2:0]             out_q,
  output logic [2:0][W+G+1:0]           out_rem,
  output logic [SIDE_W-1:0]             out_side
);
  localparam int DW    = W + G + 1;
  localparam int NQ    = W - 1;
  localparam int REM_W = DW + 1;

  logic [DW-1:0]            d_r    [0:NQ-1];
  logic [2:0][NQ-1:0]       q_r    [0:NQ-1];
  logic [2:0][REM_W-1:0]    rem_r  [0:NQ-1];
  logic [SIDE_W-1:0]        side_r [0:NQ-1];
  logic [NQ-1:0]            vld_r;
  logic [NQ-1:0]            rdy;

  // the upper quotient bits are known zero since D >= m << G: start mid-way
  logic [2:0][REM_W-1:0] rem_start;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_start[l] = {{(REM_W-W-G+1){1'b0}}, in_m[l], {(G-1){1'b0}}};
    end
  end

  genvar k;
  generate
    for (k = 0; k < NQ; k++) begin : g_stage
      logic [DW-1:0]         d_i;
      logic [2:0][NQ-1:0]    q_i;
      logic [2:0][REM_W-1:0] rem_i;
      logic [SIDE_W-1:0]     side_i;
      logic                  vld_i;
      logic [2:0][REM_W-1:0] rem_nxt;
      logic [2:0]            bit_nxt;

      if (k == 0) begin : g_first
        assign d_i    = in_d;
        assign q_i    = '0;
        assign rem_i  = rem_start;
        assign side_i = in_side;
        assign vld_i  = in_valid;
      end else begin : g_next
        assign d_i    = d_r[k-1];
        assign q_i    = q_r[k-1];
        assign rem_i  = rem_r[k-1];
        assign side_i = side_r[k-1];
        assign vld_i  = vld_r[k-1];
      end

      if (k == NQ - 1) begin : g_last_rdy
        assign rdy[k] = ~vld_r[k] | out_ready;
      end else begin : g_mid_rdy
        assign rdy[k] = ~vld_r[k] | rdy[k+1];
      end

      always_comb begin
        logic [REM_W-1:0] sh;
        for (int l = 0; l < 3; l++) begin
          sh = {rem_i[l][REM_W-2:0], 1'b0};
          bit_nxt[l] = (sh >= {1'b0, d_i});
          rem_nxt[l] = bit_nxt[l] ? (sh - {1'b0, d_i}) : sh;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld_r[k] <= vld_i;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && vld_i) begin
          d_r[k]    <= d_i;
          side_r[k] <= side_i;
          rem_r[k]  <= rem_nxt;
          for (int l = 0; l < 3; l++) begin
            q_r[k][l] <= {q_i[l][NQ-2:0], bit_nxt[l]};
          end
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NQ-1];
  assign out_d     = d_r[NQ-1];
  assign out_q     = q_r[NQ-1];
  assign out_rem   = rem_r[NQ-1];
  assign out_side  = side_r[NQ-1];
endmodule
`default_nettype wire

// ----- rtl/quaternion_to_mrp.sv -----
// Top level: quaternion to modified Rodrigues parameters converter.
`default_nettype none
// Converts one attitude quaternion (scalar first, Q2.14, any length) per beat
// into modified Rodrigues parameters in Q2.14. The quaternion is normalized
// by its Euclidean norm and the shadow set is taken whenever the scalar is
// zero or negative, so every component has magnitude at most one. Results
// are rounded half up. An all-zero input raises zero_norm_error with zero
// components. The block is a fully pipelined datapath: a new beat can enter
// every cycle unless out_tready holds the pipe, and it is built of 2 front
// stages (magnitude/square, sum), COMPONENT_WIDTH+9 square-root stages (one
// root bit per stage), one stage to form the divisor, COMPONENT_WIDTH-1
// divider stages (one quotient bit per stage, three lanes sharing the
// divisor) and one rounding/output register. Every stage holds its beat
// when the stage after it is full, so back-pressure on out_tready stalls
// only as far as needed and no beat is lost or repeated.
module quaternion_to_mrp import qmrp_pkg::*; #(
  parameter int COMPONENT_WIDTH = DEFAULT_COMPONENT_WIDTH,
  localparam int W        = COMPONENT_WIDTH,
  localparam int IN_DW    = ((4*W + 7) / 8) * 8,
  localparam int OUT_DW   = ((3*W + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // q_scalar, q_x, q_y, q_z, each W bits, from bit 0 up
  input  wire logic [IN_DW-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // mrp_x, mrp_y, mrp_z, each W bits, from bit 0 up
  output logic [OUT_DW-1:0]      out_tdata,
  // bit 0 shadow_used, bit 1 zero_norm_error
  output logic [1:0]             out_tuser
);
  localparam int G      = GUARD_BITS;
  localparam int F      = W - 2;
  localparam int DW     = W + G + 1;
  localparam int NQ     = W - 1;
  localparam int SIDE_D = 5;
  localparam int SIDE_S = 4*W + SIDE_D;

  // ---- stage 1: magnitudes and squares ----
  logic            s1_vld_r;
  logic            s1_rdy;
  logic [3:0][W-1:0]   s1_mag_r;
  logic [3:0]          s1_neg_r;
  logic [3:0][2*W-1:0] s1_sq_r;
  logic [3:0][W-1:0]   mag_nxt;
  logic [3:0]          neg_nxt;

  always_comb begin
    logic [W-1:0] raw;
    for (int i = 0; i < 4; i++) begin
      raw        = in_tdata[i*W +: W];
      neg_nxt[i] = raw[W-1];
      mag_nxt[i] = raw[W-1] ? (~raw + 1'b1) : raw;
    end
  end

  // ---- stage 2: sum of squares, flags ----
  logic            s2_vld_r;
  logic            s2_rdy;
  logic [2*W:0]    s2_sum_r;
  logic [SIDE_S-1:0] s2_side_r;
  logic [2*W:0]    sum_nxt;
  logic            shadow_nxt;
  logic [2:0]      lane_neg_nxt;

  assign sum_nxt = {1'b0, s1_sq_r[0]} + {1'b0, s1_sq_r[1]}
                 + {1'b0, s1_sq_r[2]} + {1'b0, s1_sq_r[3]};
  assign shadow_nxt = s1_neg_r[0] | (s1_mag_r[0] == '0);
  assign lane_neg_nxt = s1_neg_r[3:1] ^ {3{shadow_nxt}};

  logic sq_rdy;
  assign s1_rdy = ~s1_vld_r | s2_rdy;
  assign s2_rdy = ~s2_vld_r | sq_rdy;
  assign in_tready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld_r <= in_tvalid;
      end
      if (s2_rdy) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_tvalid) begin
      s1_mag_r <= mag_nxt;
      s1_neg_r <= neg_nxt;
      for (int i = 0; i < 4; i++) begin
        s1_sq_r[i] <= mag_nxt[i] * mag_nxt[i];
      end
    end
    if (s2_rdy && s1_vld_r) begin
      s2_sum_r  <= sum_nxt;
      // side: mags, lane negate bits, shadow, zero norm
      s2_side_r <= {s1_mag_r, lane_neg_nxt, shadow_nxt, (sum_nxt == '0)};
    end
  end

  // ---- square-root pipeline ----
  logic              sq_vld;
  logic [W+G:0]      sq_root;
  logic [SIDE_S-1:0] sq_side;
  logic              s3_rdy;

  qmrp_sqrt #(.W(W), .G(G), .SIDE_W(SIDE_S)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_vld_r),
    .in_ready  (sq_rdy),
    .in_sum    (s2_sum_r),
    .in_side   (s2_side_r),
    .out_valid (sq_vld),
    .out_ready (s3_rdy),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---- stage 3: divisor D = root + (|s| << G) ----
  logic              s3_vld_r;
  logic [DW-1:0]     s3_d_r;
  logic [2:0][W-1:0] s3_m_r;
  logic [SIDE_D-1:0] s3_side_r;
  logic              dv_rdy;
  logic [3:0][W-1:0] sq_mag;

  assign sq_mag = sq_side[SIDE_S-1:SIDE_D];
  assign s3_rdy = ~s3_vld_r | dv_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && sq_vld) begin
      s3_d_r    <= sq_root + {1'b0, sq_mag[0], {G{1'b0}}};
      s3_m_r    <= sq_mag[3:1];
      s3_side_r <= sq_side[SIDE_D-1:0];
    end
  end

  // ---- divider pipeline ----
  logic                   dv_vld;
  logic [DW-1:0]          dv_d;
  logic [2:0][NQ-1:0]     dv_q;
  logic [2:0][DW:0]       dv_rem;
  logic [SIDE_D-1:0]      dv_side;
  logic                   o_rdy;

  qmrp_div #(.W(W), .G(G), .SIDE_W(SIDE_D)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_vld_r),
    .in_ready  (dv_rdy),
    .in_d      (s3_d_r),
    .in_m      (s3_m_r),
    .in_side   (s3_side_r),
    .out_valid (dv_vld),
    .out_ready (o_rdy),
    .out_d     (dv_d),
    .out_q     (dv_q),
    .out_rem   (dv_rem),
    .out_side  (dv_side)
  );

  // ---- output stage: round half up, clamp to one, apply sign, zero on zero norm ----
  logic               o_vld_r;
  logic [3*W-1:0]     o_data_r;
  logic [1:0]         o_user_r;
  logic [3*W-1:0]     data_nxt;
  logic [2:0]         dv_neg;
  logic               dv_shadow;
  logic               dv_zero;

  assign dv_neg    = dv_side[4:2];
  assign dv_shadow = dv_side[1];
  assign dv_zero   = dv_side[0];
  assign o_rdy     = ~o_vld_r | out_tready;

  always_comb begin
    logic         rnd;
    logic [W-1:0] qr;
    logic [W-1:0] mag;
    for (int l = 0; l < 3; l++) begin
      rnd = ({dv_rem[l], 1'b0} >= {2'b00, dv_d});
      qr  = {1'b0, dv_q[l]} + {{(W-1){1'b0}}, rnd};
      mag = (qr > (W'(1) << F)) ? (W'(1) << F) : qr;
      if (dv_zero) begin
        data_nxt[l*W +: W] = '0;
      end else begin
        data_nxt[l*W +: W] = dv_neg[l] ? (~mag + 1'b1) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_rdy) begin
      o_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && dv_vld) begin
      o_data_r <= data_nxt;
      o_user_r <= {dv_zero, dv_shadow & ~dv_zero};
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {{(OUT_DW-3*W){1'b0}}, o_data_r};
  assign out_tuser  = o_user_r;

`ifndef SYNTHESIS
  // a zero-norm beat carries zero components and no shadow flag
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tdata == '0) && !out_tuser[0])
    else $error("zero-norm result not cleared");

  // mrp_x stays within plus or minus one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[W-1:0]) <= $signed(W'(1) << F))
      && ($signed(out_tdata[W-1:0]) >= -$signed(W'(1) << F)))
    else $error("mrp_x out of range");

  // with the output stage empty the whole pipeline can take a beat
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");
`endif
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench for quaternion_to_mrp: directed and random quaternions checked beat by beat.
module tb_top;
  import qmrp_pkg::*;

  localparam int W       = DEFAULT_COMPONENT_WIDTH;
  localparam int G       = GUARD_BITS;
  localparam int F       = W - 2;
  localparam int IN_DW   = ((4*W + 7) / 8) * 8;
  localparam int OUT_DW  = ((3*W + 7) / 8) * 8;
  localparam int LATENCY = 2*W + 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 870;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [W-1:0] mrp_z;
    logic [W-1:0] mrp_y;
    logic [W-1:0] mrp_x;
    logic         shadow_used;
    logic         zero_norm_error;
  } mrp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic [1:0] out_tuser;

  // Receiver controls (random stalls on/off, a long hold-off in cycles) and sender gaps on/off.
  bit sink_idle_en = 1'b1;
  int sink_hold = 0;
  bit src_idle_en = 1'b1;

  mrp_t expected_mrp_q[$];
  int n_mismatch = 0;
  int n_results = 0;
  int n_items = 0;
  int n_shadow = 0;
  int n_zero = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  quaternion_to_mrp dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    // q_scalar, q_x, q_y, q_z from bit 0 up
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    // mrp_x, mrp_y, mrp_z from bit 0 up
    .out_tdata(out_tdata),
    // bit 0 shadow_used, bit 1 zero_norm_error
    .out_tuser(out_tuser)
  );

  // Absolute value of a W-bit two's complement word; the most negative
  // code maps to 2^(W-1) exactly.
  function automatic logic [W:0] abs_word(logic [W-1:0] raw);
    return raw[W-1] ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
  endfunction

  // Bitwise integer square root, floor.
  function automatic logic [47:0] isqrt(logic [95:0] val);
    logic [95:0] rem;
    logic [95:0] root;
    logic [95:0] trial;
    rem = '0;
    root = '0;
    for (int i = 47; i >= 0; i--) begin
      rem = (rem << 2) | ((val >> (2*i)) & 96'd3);
      trial = (root << 2) | 96'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 96'd1;
      end
    end
    return root[47:0];
  endfunction

  // Normalize, pick the MRP or shadow set, divide with round half up.
  function automatic mrp_t convert_quat(logic [4*W-1:0] q);
    mrp_t r;
    logic [W:0] mag [4];
    logic [95:0] sumsq;
    logic [95:0] divisor;
    logic [95:0] num;
    logic [95:0] quo;
    logic [95:0] rem;
    logic [W-1:0] comp;
    bit shadow;
    sumsq = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = abs_word(q[i*W +: W]);
      sumsq += 96'(mag[i]) * 96'(mag[i]);
    end
    r = '0;
    if (sumsq == 0) begin
      r.zero_norm_error = 1'b1;
      return r;
    end
    shadow = q[W-1] || (mag[0] == 0);
    divisor = 96'(isqrt(sumsq << (2*G))) + (96'(mag[0]) << G);
    for (int i = 1; i < 4; i++) begin
      num = 96'(mag[i]) << (F + G);
      quo = num / divisor;
      rem = num % divisor;
      if ((rem << 1) >= divisor) quo++;
      if (quo > (96'd1 << F)) quo = 96'd1 << F;
      comp = quo[W-1:0];
      if (q[i*W + W-1] != shadow) comp = -comp;
      case (i)
        1: r.mrp_x = comp;
        2: r.mrp_y = comp;
        default: r.mrp_z = comp;
      endcase
    end
    r.shadow_used = shadow;
    return r;
  endfunction

  // Offer one quaternion, hold it until accepted, record its expected MRP.
  task automatic send_quat(logic [W-1:0] s, logic [W-1:0] x, logic [W-1:0] y,
                           logic [W-1:0] z);
    int gap;
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DW'({z, y, x, s});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_mrp_q.push_back(convert_quat({z, y, x, s}));
    n_items++;
  endtask

  task automatic drop_valid();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (expected_mrp_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [W-1:0] rand_word();
    return W'($urandom);
  endfunction

  // Field extremes, zero norm, zero scalar, scalar -1 and most negative codes.
  task automatic test_directed();
    logic [W-1:0] mx;
    logic [W-1:0] mn;
    logic [W-1:0] one;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    one = W'(1) << F;
    send_quat('0, '0, '0, '0);
    send_quat(one, '0, '0, '0);
    send_quat(-one, '0, '0, '0);
    send_quat(mn, '0, '0, '0);
    send_quat('0, one, '0, '0);
    send_quat('0, '0, -one, '0);
    send_quat('0, mn, mn, mn);
    send_quat(mn, mn, mn, mn);
    send_quat(mx, mx, mx, mx);
    send_quat(mx, mn, mx, mn);
    send_quat(mn, mx, mn, mx);
    send_quat(W'(1), mx, mx, mx);
    send_quat(-W'(1), mx, mx, mx);
    send_quat(W'(1), '0, '0, '0);
    send_quat('0, '0, '0, W'(1));
    send_quat({W{1'b1}}, {W{1'b1}}, {W{1'b1}}, {W{1'b1}});
    send_quat(W'(11585), W'(11585), '0, '0);
    send_quat(-W'(11585), '0, W'(11585), '0);
    send_quat('0, mx, '0, mn);
    send_quat(one, one, one, one);
    wait_drained();
  endtask

  // Random quaternions: mostly full-range words, some small, some sparse.
  task automatic test_random(int count);
    logic [W-1:0] c [4];
    int shape;
    for (int n = 0; n < count; n++) begin
      shape = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++) begin
        if (shape < 6) c[i] = rand_word();
        else if (shape < 8) c[i] = W'($signed($urandom_range(0, 64)) - 32);
        else c[i] = ($urandom_range(0, 1) != 0) ? rand_word() : '0;
      end
      send_quat(c[0], c[1], c[2], c[3]);
    end
  endtask

  // Long receiver hold-off while the sender keeps offering, filling the pipe.
  task automatic test_backpressure();
    sink_hold = 300;
    test_random(80);
    wait_drained();
  endtask

  // Final stretch with neither side idling.
  task automatic test_streaming();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    test_random(150);
    wait_drained();
  endtask

  // Receiver: random stall bursts, or a counted hold-off when asked.
  initial begin : sink_proc
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        sink_hold--;
      end else if (burst > 0) begin
        out_tready <= 1'b0;
        burst--;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        burst = $urandom_range(0, 9);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    mrp_t got;
    mrp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[3*W-1:0], out_tuser[0], out_tuser[1]};
      n_results++;
      if (expected_mrp_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("unexpected result beat: %h", got);
      end else begin
        want = expected_mrp_q.pop_front();
        if (want.shadow_used) n_shadow++;
        if (want.zero_norm_error) n_zero++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("mismatch #%0d: x %h/%h y %h/%h z %h/%h shadow %b/%b zero %b/%b",
                     n_results, want.mrp_x, got.mrp_x, want.mrp_y, got.mrp_y,
                     want.mrp_z, got.mrp_z, want.shadow_used, got.shadow_used,
                     want.zero_norm_error, got.zero_norm_error);
        end
      end
    end
  end

  // Watchdog: count cycles with no beat accepted on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", expected_mrp_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(N_RANDOM - 230);
    wait_drained();
    test_backpressure();
    test_streaming();
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d quaternions: %0d shadow-set results, %0d zero-norm inputs",
             n_items, n_shadow, n_zero);
    $display("includes a long output hold-off and a back-to-back stream");
    if (n_mismatch == 0 && expected_mrp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, expected_mrp_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
